### rtl/tcv_pkg.sv
// Package for the ternary 3x3 convolution block.
// Holds widths, register indexes and weight codes shared by the RTL and checker.
// No dependencies.
package tcv_pkg;

    localparam int WIN_SIZE   = 3;
    localparam int CONV_W     = 20;
    localparam int DOUT_W     = 24;
    localparam int SIDE_CFG_W = 8;
    localparam int KERNEL_W   = 18;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_SIDE = 2'd0,
        REG_KERNEL     = 2'd1
    } cfg_reg_t;

    localparam logic [1:0] WGT_PLUS  = 2'd1;
    localparam logic [1:0] WGT_MINUS = 2'd3;

endpackage

### rtl/tcv_linebuf.sv
// Two line memories for the 3x3 window: middle row and top row.
// Registered reads; the top row is written from the registered middle read.
// No package dependencies.
module tcv_linebuf #(
    parameter int DEPTH  = 128,
    parameter int DATA_W = 16,
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic [DATA_W-1:0] mid_wr_data,
    input  logic              top_we,
    input  logic [ADDR_W-1:0] top_addr,
    input  logic [DATA_W-1:0] top_wr_data,
    output logic [DATA_W-1:0] top_q,
    output logic [DATA_W-1:0] mid_q
);

    logic [DATA_W-1:0] mem_mid [DEPTH];
    logic [DATA_W-1:0] mem_top [DEPTH];
    logic [DATA_W-1:0] top_q_reg;
    logic [DATA_W-1:0] mid_q_reg;

    // read-before-write on the same address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mid_q_reg        <= mem_mid[rd_addr];
            mem_mid[rd_addr] <= mid_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            top_q_reg <= mem_top[rd_addr];
        end
        if (top_we)
        begin
            mem_top[top_addr] <= top_wr_data;
        end
    end

    assign top_q = top_q_reg;
    assign mid_q = mid_q_reg;

endmodule

### rtl/ternary_conv3x3_valid.sv
// Top level of the ternary-weight 3x3 valid convolution.
// Depends on tcv_pkg and tcv_linebuf.
//
// Usage:
//   s_* carries one sample per item in raster order; frames follow back to back.
//   m_* carries one result per window lying fully inside the frame:
//   tdata = conv_value, tuser = row_end, tlast = frame_end.
//   cfg_* writes registers: index 0 frame_side (restarts the frame),
//   index 1 kernel_weights. cfg_ready is always high; write only while idle.
//   Pipeline: a sample passes the line memory read, the window shift and the
//   adder tree into the output register, one register stage each, before
//   its result is shown on m_tvalid.
//   Throughput: one item per cycle unless stalled; each line memory does one
//   read and one write per sample, the top row write trailing its read by one stage.
//   Reset: counters and pipeline valids clear, frame_side = 3, weights = 0.
//   Line memories are not cleared; entries are always written before use.
//   Stall: when m_tready is low the pipeline fills its empty stages first;
//   s_tready drops only once every stage and the output register hold items.
module ternary_conv3x3_valid
    import tcv_pkg::*;
#(
    parameter int MAX_SIZE    = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [DOUT_W-1:0]                   m_tdata,   // [19:0] conv_value
    output logic                                m_tuser,   // row_end
    output logic                                m_tlast,   // frame_end
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_data
);

    localparam int CNT_W  = $clog2(MAX_SIZE);
    localparam int SIDE_W = $clog2(MAX_SIZE + 1);
    localparam int CMP_W  = ((SIDE_W > SIDE_CFG_W) ? SIDE_W : SIDE_CFG_W) + 1;
    localparam int SUM_W  = SAMPLE_BITS + 4;

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;
    typedef logic signed [SUM_W-1:0]       sum_t;

    // configuration
    logic [SIDE_W-1:0]   side_reg;
    logic [SIDE_W-1:0]   side_next;
    logic [KERNEL_W-1:0] weights_reg;
    logic [CMP_W-1:0]    fs_ext;
    logic                cfg_we;

    // position
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic             last_col, last_row;
    logic             accept;

    // stage 1: line memory read in flight
    logic             v1_reg;
    smp_t             s1_reg;
    logic [CNT_W-1:0] c1_reg;
    logic             prod1_reg, rend1_reg, fend1_reg;
    logic [SAMPLE_BITS-1:0] top_q, mid_q;

    // stage 2: window loaded
    logic v2_reg;
    logic prod2_reg, rend2_reg, fend2_reg;
    smp_t win_reg [WIN_SIZE][WIN_SIZE];

    // output register
    logic              out_valid_reg;
    logic [CONV_W-1:0] conv_reg;
    logic              rend_reg, fend_reg;

    logic adv0, adv1, adv2, move1;

    sum_t row_sum [WIN_SIZE];
    sum_t total;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        fs_ext = CMP_W'(cfg_data[SIDE_CFG_W-1:0]);
        if (fs_ext < CMP_W'(WIN_SIZE))
        begin
            side_next = SIDE_W'(WIN_SIZE);
        end
        else if (fs_ext > CMP_W'(MAX_SIZE))
        begin
            side_next = SIDE_W'(MAX_SIZE);
        end
        else
        begin
            side_next = SIDE_W'(fs_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg    <= SIDE_W'(WIN_SIZE);
            weights_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_SIDE: side_reg    <= side_next;
                REG_KERNEL:     weights_reg <= cfg_data[KERNEL_W-1:0];
                default:        ;
            endcase
        end
    end

    // pipeline flow: empty stages absorb a stall
    assign adv2     = !out_valid_reg || m_tready;
    assign adv1     = !v2_reg || adv2;
    assign adv0     = !v1_reg || adv1;
    assign move1    = v1_reg && adv1;
    assign s_tready = adv0;
    assign accept   = s_tvalid && s_tready;

    assign last_col = SIDE_W'(col_reg) == (side_reg - SIDE_W'(1));
    assign last_row = SIDE_W'(row_reg) == (side_reg - SIDE_W'(1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cfg_we && cfg_index == REG_FRAME_SIDE)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    tcv_linebuf #(
        .DEPTH  (MAX_SIZE),
        .DATA_W (SAMPLE_BITS),
        .ADDR_W (CNT_W)
    ) u_linebuf (
        .clk         (clk),
        .rd_en       (accept),
        .rd_addr     (col_reg),
        .mid_wr_data (s_tdata[SAMPLE_BITS-1:0]),
        .top_we      (move1),
        .top_addr    (c1_reg),
        .top_wr_data (mid_q),
        .top_q       (top_q),
        .mid_q       (mid_q)
    );

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv0)
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg    <= smp_t'(s_tdata[SAMPLE_BITS-1:0]);
            c1_reg    <= col_reg;
            prod1_reg <= (row_reg >= CNT_W'(2)) && (col_reg >= CNT_W'(2));
            rend1_reg <= last_col;
            fend1_reg <= last_col && last_row;
        end
    end

    // stage 2: window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv1)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move1)
        begin
            for (int x = 0; x < WIN_SIZE; x++)
            begin
                win_reg[x][0] <= win_reg[x][1];
                win_reg[x][1] <= win_reg[x][2];
            end
            win_reg[0][2] <= smp_t'(top_q);
            win_reg[1][2] <= smp_t'(mid_q);
            win_reg[2][2] <= s1_reg;
            prod2_reg     <= prod1_reg;
            rend2_reg     <= rend1_reg;
            fend2_reg     <= fend1_reg;
        end
    end

    // ternary adder tree
    always_comb
    begin
        for (int x = 0; x < WIN_SIZE; x++)
        begin
            row_sum[x] = '0;
            for (int y = 0; y < WIN_SIZE; y++)
            begin
                case (weights_reg[2*(x*WIN_SIZE+y) +: 2])
                    WGT_PLUS:  row_sum[x] = row_sum[x] + sum_t'(win_reg[x][y]);
                    WGT_MINUS: row_sum[x] = row_sum[x] - sum_t'(win_reg[x][y]);
                    default:   ;
                endcase
            end
        end
        total = row_sum[0] + row_sum[1] + row_sum[2];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv2)
        begin
            out_valid_reg <= v2_reg && prod2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v2_reg && prod2_reg)
        begin
            conv_reg <= CONV_W'(total);
            rend_reg <= rend2_reg;
            fend_reg <= fend2_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DOUT_W'(conv_reg);
    assign m_tuser  = rend_reg;
    assign m_tlast  = fend_reg;

endmodule

### rtl/tcv_checker.sv
// Port-level checker for ternary_conv3x3_valid, attached by bind.
// Depends on tcv_pkg.
module tcv_checker
    import tcv_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DOUT_W-1:0] m_tdata,
    input logic              m_tuser,
    input logic              m_tlast
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_drop_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result withdrawn before taken");

    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("frame end without row end");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output free");

endmodule

bind ternary_conv3x3_valid tcv_checker u_tcv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
